// ----- rtl/dependency_transitive_closure_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Dependency transitive closure unit: assertion macros
// Concurrent assertion wrappers clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DEPENDENCY_TRANSITIVE_CLOSURE_UNIT_ASSERT_SVH
`define DEPENDENCY_TRANSITIVE_CLOSURE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DTC_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define DTC_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define DTC_ASSERT_IMP(label, ante, cons)
`define DTC_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- rtl/dtc_pkg.sv -----
// ----------------------------------------------------------------------------
// Dependency transitive closure package
// Field widths, queue sizing and the request type passed from front to back.
// ----------------------------------------------------------------------------
package dtc_pkg;
	localparam int NODE_W      = 5;
	localparam int MASK_W      = 32;
	localparam int ROW_SLOTS   = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [MASK_W-1:0] deps;
		logic              store;
		logic              last;
	} dtc_req_t;
endpackage

// ----- rtl/dtc_front.sv -----
// ----------------------------------------------------------------------------
// Dependency transitive closure front end
// Accepts input requests, classifies the node index and trims the mask.
// ----------------------------------------------------------------------------
module dtc_front #(
	parameter int NODE_COUNT = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  logic [dtc_pkg::NODE_W-1:0] node,
	input  logic [dtc_pkg::MASK_W-1:0] direct_deps,
	input  logic                      last,
	output logic                      push,
	output dtc_pkg::dtc_req_t         push_req,
	input  logic                      queue_full
);
	import dtc_pkg::*;

	localparam int NODES_USED = (NODE_COUNT < ROW_SLOTS) ? NODE_COUNT : ROW_SLOTS;
	localparam logic [MASK_W-1:0] USED_MASK = {MASK_W{1'b1}} >> (MASK_W - NODES_USED);

	logic     req_valid_s1;
	dtc_req_t req_s1;

	assign item_stall = req_valid_s1 && queue_full;
	assign push       = req_valid_s1 && !queue_full;
	assign push_req   = req_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			req_valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			req_s1.node  <= node;
			req_s1.deps  <= direct_deps & USED_MASK;
			req_s1.store <= ({1'b0, node} < (NODE_W + 1)'(NODES_USED));
			req_s1.last  <= last;
		end
	end
endmodule

// ----- rtl/dtc_queue.sv -----
// ----------------------------------------------------------------------------
// Dependency transitive closure request queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
`include "dependency_transitive_closure_unit_assert.svh"

module dtc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dtc_pkg::dtc_req_t push_req,
	output logic              full,
	input  logic              pop,
	output dtc_pkg::dtc_req_t pop_req,
	output logic              empty
);
	import dtc_pkg::*;

	dtc_req_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full    = (count_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_req = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_req;
		end
	end

	`DTC_ASSERT_IMP(a_count_bound, 1'b1, count_q <= (QPTR_W + 1)'(QUEUE_DEPTH))
	`DTC_ASSERT_IMP(a_no_pop_empty, pop, count_q != '0)
	`DTC_ASSERT_NXT(a_push_grows, push && !pop, count_q == $past(count_q) + 1'b1)
endmodule

// ----- rtl/dtc_back.sv -----
// ----------------------------------------------------------------------------
// Dependency transitive closure back end
// Holds the row store, runs the closure one pivot a cycle and emits the rows.
// ----------------------------------------------------------------------------
`include "dependency_transitive_closure_unit_assert.svh"

module dtc_back #(
	parameter int NODE_COUNT = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       empty,
	input  dtc_pkg::dtc_req_t          pop_req,
	output logic                       pop,
	output logic                       row_valid,
	input  logic                       row_stall,
	output logic [dtc_pkg::NODE_W-1:0] row_node,
	output logic [dtc_pkg::MASK_W-1:0] all_deps,
	output logic                       row_last
);
	import dtc_pkg::*;

	localparam int NODES_USED = (NODE_COUNT < ROW_SLOTS) ? NODE_COUNT : ROW_SLOTS;
	localparam int IDX_W      = $clog2(NODES_USED);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NODES_USED - 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_CLOSE = 3'b010,
		ST_EMIT  = 3'b100
	} state_t;

	state_t             state_q;
	state_t             state_d;
	logic [IDX_W-1:0]   cnt_q;
	logic [MASK_W-1:0]  rows_q [NODES_USED];
	logic [MASK_W-1:0]  sel_row;
	logic               emit_load;
	logic               cnt_end;
	logic               row_valid_q;
	logic [NODE_W-1:0]  row_node_q;
	logic [MASK_W-1:0]  all_deps_q;
	logic               row_last_q;

	assign pop       = (state_q == ST_IDLE) && !empty;
	assign sel_row   = rows_q[cnt_q];
	assign cnt_end   = (cnt_q == LAST_IDX);
	assign emit_load = (state_q == ST_EMIT) && (!row_valid_q || !row_stall);

	assign row_valid = row_valid_q;
	assign row_node  = row_node_q;
	assign all_deps  = all_deps_q;
	assign row_last  = row_last_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (pop && pop_req.last) begin
					state_d = ST_CLOSE;
				end
			end
			ST_CLOSE: begin
				if (cnt_end) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (emit_load && cnt_end) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE) begin
				cnt_q <= '0;
			end else if ((state_q == ST_CLOSE) || emit_load) begin
				cnt_q <= cnt_end ? '0 : cnt_q + 1'b1;
			end
		end
	end

	// Each row that names the current pivot absorbs the pivot row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NODES_USED; i++) begin
				rows_q[i] <= '0;
			end
		end else begin
			priority if (emit_load && cnt_end) begin
				for (int i = 0; i < NODES_USED; i++) begin
					rows_q[i] <= '0;
				end
			end else if (state_q == ST_CLOSE) begin
				for (int i = 0; i < NODES_USED; i++) begin
					if (rows_q[i][cnt_q]) begin
						rows_q[i] <= rows_q[i] | sel_row;
					end
				end
			end else if (pop && pop_req.store) begin
				rows_q[pop_req.node[IDX_W-1:0]] <= pop_req.deps;
			end else begin
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= 1'b0;
		end else if (emit_load) begin
			row_valid_q <= 1'b1;
		end else if (!row_stall) begin
			row_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			row_node_q <= NODE_W'(cnt_q);
			all_deps_q <= sel_row;
			row_last_q <= cnt_end;
		end
	end

	`DTC_ASSERT_NXT(a_close_to_emit, (state_q == ST_CLOSE) && cnt_end, state_q == ST_EMIT)
	`DTC_ASSERT_NXT(a_emit_done, emit_load && cnt_end, (state_q == ST_IDLE) && row_last_q)
	`DTC_ASSERT_NXT(a_emit_hold, (state_q == ST_EMIT) && !emit_load, $stable(cnt_q))
endmodule

// ----- rtl/dependency_transitive_closure_unit.sv -----
// ----------------------------------------------------------------------------
// Dependency transitive closure unit
// Loads a dependency graph row by row, closes it and streams the closed rows.
// ----------------------------------------------------------------------------
// Each input request carries a node, its direct dependency mask and a last
// flag; requests move on item_valid while item_stall is low. Rows load at one
// per cycle while item_stall is low, through a front stage and a four-entry
// queue. A request marked last starts the closure, which applies one pivot
// row per cycle, one for each used node, to every row at once. Emission then
// gives one row per cycle on row_valid/row_stall while row_stall is low, in
// node order, with row_last on the final row. Nodes never loaded come out
// with an empty mask. While the closure and emission run, the queue can fill
// and raise item_stall. When the receiver stalls, the output register holds
// its row and emission pauses. Reset empties the store, the queue and the
// output register; the store also clears itself once the final row of a run
// is emitted.
// ----------------------------------------------------------------------------
module dependency_transitive_closure_unit #(
	parameter int NODE_COUNT = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [dtc_pkg::NODE_W-1:0] node,
	input  logic [dtc_pkg::MASK_W-1:0] direct_deps,
	input  logic                       last,
	output logic                       row_valid,
	input  logic                       row_stall,
	output logic [dtc_pkg::NODE_W-1:0] row_node,
	output logic [dtc_pkg::MASK_W-1:0] all_deps,
	output logic                       row_last
);
	import dtc_pkg::*;

	logic     push;
	dtc_req_t push_req;
	logic     queue_full;
	logic     pop;
	dtc_req_t pop_req;
	logic     queue_empty;

	dtc_front #(
		.NODE_COUNT(NODE_COUNT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.node       (node),
		.direct_deps(direct_deps),
		.last       (last),
		.push       (push),
		.push_req   (push_req),
		.queue_full (queue_full)
	);

	dtc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_req(push_req),
		.full    (queue_full),
		.pop     (pop),
		.pop_req (pop_req),
		.empty   (queue_empty)
	);

	dtc_back #(
		.NODE_COUNT(NODE_COUNT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (queue_empty),
		.pop_req  (pop_req),
		.pop      (pop),
		.row_valid(row_valid),
		.row_stall(row_stall),
		.row_node (row_node),
		.all_deps (all_deps),
		.row_last (row_last)
	);
endmodule
